>>> hw/rtl/ge3_pkg.sv
// ----------------------------------------------------------------------------
// ge3_pkg - shared types and constants for the 3x3 grayscale erosion block
// Field widths, register indexes, reset values and the item record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package ge3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int MASK_W      = 9;
  localparam int PIX_W       = 8;
  localparam int ROW_W       = HEIGHT_REG_W + 1;   // row runs to height + 2
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  localparam logic [PIX_W-1:0]        PIX_MAX = '1;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);
  localparam logic [MASK_W-1:0]       MASK_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_MASK  = 2'd2
  } cfg_reg_t;

  // one accepted pixel, already classified
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pix;
    logic              fstart;
    logic              emit;
    logic [MASK_W-1:0] en;
    logic              last;
  } item_t;

endpackage

>>> hw/rtl/ge3_front.sv
// ----------------------------------------------------------------------------
// ge3_front - input position tracking and item classification
// Holds the configuration registers and the raster position, decides for
// each beat its line-store column, pixel value, whether it yields a result
// and which window taps are enabled, and pushes the item to the queue.
// ----------------------------------------------------------------------------
module ge3_front import ge3_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIX_W-1:0]        in_pixel_value,
  input  logic                    in_frame_start,
  input  logic                    in_flush,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  localparam int CROW_W = ROW_W + 1;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [MASK_W-1:0]       mask_r;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;

  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [ROW_W-1:0]        row0;
  logic [COL_W-1:0]        col0;
  logic                    drop;
  logic                    accept;
  logic signed [CROW_W-1:0] crow;
  logic [ROW_W-1:0]        crow_u;
  logic [WIDTH_REG_W-1:0]  ccol;
  logic                    emit;
  logic [2:0]              row_ok, col_ok;
  logic [WIDTH_REG_W-1:0]  col_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HEIGHT_REG_W'(1) : height_r;
  end

  always_comb begin
    row0 = in_frame_start ? '0 : row_r;
    col0 = in_frame_start ? '0 : col_r;
    drop = row0 > (ROW_W'(h_eff) + ROW_W'(1));

    // center sits one row and one column behind the input; at column 0, the last column two rows up
    if (col0 != '0) begin
      crow = CROW_W'(row0) - CROW_W'(1);
      ccol = WIDTH_REG_W'(col0) - WIDTH_REG_W'(1);
    end else begin
      crow = CROW_W'(row0) - CROW_W'(2);
      ccol = w_eff - WIDTH_REG_W'(1);
    end
    crow_u = crow[ROW_W-1:0];
    emit = !crow[CROW_W-1] && (crow_u < ROW_W'(h_eff)) && (ccol < w_eff);

    row_ok[0] = crow_u != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = (crow_u + ROW_W'(1)) < ROW_W'(h_eff);
    col_ok[0] = ccol != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = (ccol + WIDTH_REG_W'(1)) < w_eff;

    q_item.col    = col0;
    q_item.pix    = (in_flush || row0 >= ROW_W'(h_eff)) ? PIX_MAX : in_pixel_value;
    q_item.fstart = in_frame_start;
    q_item.emit   = emit;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q_item.en[r*3+c] = mask_r[r*3+c] && row_ok[r] && col_ok[c];
      end
    end
    q_item.last = (crow_u == ROW_W'(h_eff) - ROW_W'(1)) && (ccol == w_eff - WIDTH_REG_W'(1));

    q_push = accept && !drop;

    col_inc = WIDTH_REG_W'(col0) + WIDTH_REG_W'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row0 + ROW_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mask_r   <= MASK_RST;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_REG_W-1:0];
          REG_KERNEL_MASK:  mask_r   <= cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/ge3_fifo.sv
// ----------------------------------------------------------------------------
// ge3_fifo - short item queue between front end and back end
// Register-based circular buffer; head is visible while not empty.
// ----------------------------------------------------------------------------
module ge3_fifo import ge3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t                 buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_pop;

  assign full       = cnt_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = buf_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/ge3_back.sv
// ----------------------------------------------------------------------------
// ge3_back - line stores, 3x3 window and masked minimum
// Pipeline: line-store read, window shift and write-back, row minima,
// final minimum into the output register. The whole pipe advances
// together whenever the output register can take a new beat.
// ----------------------------------------------------------------------------
module ge3_back import ge3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  item_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_eroded_value,
  output logic              out_frame_last
);

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    min8 = (a < b) ? a : b;
  endfunction

  logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];

  logic             adv;

  // read stage
  logic             b_vld_r;
  item_t            b_item_r;
  logic [PIX_W-1:0] rd_a_r, rd_b_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_top_r, byp_mid_r;
  logic [PIX_W-1:0] b_top, b_mid;

  // window stage
  logic             c_vld_r;
  logic             c_emit_r;
  logic [MASK_W-1:0] c_en_r;
  logic             c_last_r;
  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] row_min [3];

  // row-minimum stage
  logic             d_vld_r;
  logic             d_last_r;
  logic [PIX_W-1:0] d_min_r [3];

  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_last_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  // same-column write in flight: take the values being written
  assign b_top = byp_r ? byp_top_r : rd_b_r;
  assign b_mid = byp_r ? byp_mid_r : rd_a_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        rd_a_r <= line_a_mem[head.col];
        rd_b_r <= line_b_mem[head.col];
      end
      if (b_vld_r) begin
        line_a_mem[b_item_r.col] <= b_item_r.pix;
        line_b_mem[b_item_r.col] <= b_mid;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_min[r] = PIX_MAX;
      for (int c = 0; c < 3; c++) begin
        if (c_en_r[r*3+c]) begin
          row_min[r] = min8(row_min[r], win_r[r][c]);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r  <= head;
      byp_top_r <= b_mid;
      byp_mid_r <= b_item_r.pix;
      c_en_r    <= b_item_r.en;
      c_last_r  <= b_item_r.last;
      d_min_r   <= row_min;
      d_last_r  <= c_last_r;
      out_value_r <= min8(min8(d_min_r[0], d_min_r[1]), d_min_r[2]);
      out_last_r  <= d_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      byp_r       <= 1'b0;
      c_vld_r     <= 1'b0;
      c_emit_r    <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= PIX_MAX;
        end
      end
    end else if (adv) begin
      b_vld_r     <= pop;
      byp_r       <= pop && b_vld_r && (head.col == b_item_r.col);
      c_vld_r     <= b_vld_r;
      c_emit_r    <= b_vld_r && b_item_r.emit;
      d_vld_r     <= c_vld_r && c_emit_r;
      out_valid_r <= d_vld_r;
      if (b_vld_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= b_item_r.fstart ? PIX_MAX : win_r[r][1];
          win_r[r][1] <= b_item_r.fstart ? PIX_MAX : win_r[r][2];
        end
        win_r[0][2] <= b_top;
        win_r[1][2] <= b_mid;
        win_r[2][2] <= b_item_r.pix;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_eroded_value = out_value_r;
  assign out_frame_last   = out_last_r;

endmodule

>>> hw/rtl/grayscale_erosion_3x3.sv
// ----------------------------------------------------------------------------
// grayscale_erosion_3x3 - 3x3 grayscale morphological erosion, streaming
// Raster-order 8-bit pixels in, eroded pixels out.
//
// Input channel (in_*): one pixel per beat; in_frame_start marks pixel
// (0,0), in_flush marks a padding beat. Send one row plus one pixel of
// flush beats after a frame to drain its last results.
// Output channel (out_*): the minimum over the enabled taps of
// kernel_mask that fall inside the image; out_frame_last flags the
// bottom-right pixel. The result for pixel p follows input beat
// p + width + 1, via the queue, read, window, row-minimum and output stages.
// Throughput: one beat per cycle on both channels while unstalled; the line
// stores are single-port-read per cycle, read-modify-write per column.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Reset: registers return to 640 x 480 with a full mask, the position
// clears and the window goes to white; line stores are not cleared.
// Stalls: out_stall freezes the back pipeline; a 4-entry queue keeps
// input flowing until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module grayscale_erosion_3x3 import ge3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic                  in_frame_start,
  input  logic                  in_flush,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_eroded_value,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_pop;
  logic  q_head_valid;
  item_t q_head;

  ge3_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .in_frame_start (in_frame_start),
    .in_flush       (in_flush),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  ge3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ge3_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_eroded_value (out_eroded_value),
    .out_frame_last   (out_frame_last)
  );

endmodule

>>> hw/rtl/ge3_checker.sv
// ----------------------------------------------------------------------------
// ge3_checker - port-level checks for the erosion block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module ge3_checker import ge3_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIX_W-1:0]      out_eroded_value,
  input logic                  out_frame_last
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_eroded_value) && $stable(out_frame_last))
    else $error("output payload changed while stalled");

  // reset empties the pipeline and the queue
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall high right after reset");

endmodule

bind grayscale_erosion_3x3 ge3_checker u_ge3_checker (.*);

>>> test/ge3_erosion_checker.sv
// ----------------------------------------------------------------------------
// ge3_erosion_checker - result predictor and scoreboard for the erosion block
// Watches the configuration port and both pixel channels. Every accepted
// input beat runs through a cycle-free model of the line stores and the
// 3x3 window; every accepted output beat is compared with the oldest
// predicted pixel. Mismatches are counted and handed to the testbench.
// ----------------------------------------------------------------------------
module ge3_erosion_checker import ge3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic                  in_frame_start,
  input  logic                  in_flush,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIX_W-1:0]      out_eroded_value,
  input  logic                  out_frame_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    expect_depth
);

  localparam int TAPS = 3;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } eroded_px_t;

  eroded_px_t eroded_q[$];

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [MASK_W-1:0]       mask_r;

  logic [PIX_W-1:0] line_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_b [MAX_WIDTH];
  logic [PIX_W-1:0] win [TAPS][TAPS];
  logic [ROW_W-1:0] row_pos;
  logic [COL_W:0]   col_pos;   // one bit wider so the last column can wrap

  function automatic void fill_window();
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS; c++) begin
        win[r][c] = PIX_MAX;
      end
    end
  endfunction

  function automatic void predict_beat(logic [PIX_W-1:0] pv, logic fs, logic fl);
    int w;
    int h;
    int crow;
    int ccol;
    int nr;
    int nc;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] lowest;
    eroded_px_t res;
    w = (width_r == 0) ? 1 : (width_r > MAX_WIDTH) ? MAX_WIDTH : int'(width_r);
    h = (height_r == 0) ? 1 : int'(height_r);
    if (fs) begin
      row_pos = '0;
      col_pos = '0;
      fill_window();
    end
    // drained: nothing moves until the next frame start
    if (int'(row_pos) > h + 1) return;
    px = (fl || int'(row_pos) >= h) ? PIX_MAX : pv;
    up = PIX_MAX;
    md = PIX_MAX;
    if (col_pos < MAX_WIDTH) begin
      up = line_b[col_pos[COL_W-1:0]];
      md = line_a[col_pos[COL_W-1:0]];
      line_b[col_pos[COL_W-1:0]] = md;
      line_a[col_pos[COL_W-1:0]] = px;
    end
    for (int r = 0; r < TAPS; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = md;
    win[2][2] = px;
    // center sits one column back, or at the end of the row two rows up
    if (col_pos != 0) begin
      crow = int'(row_pos) - 1;
      ccol = int'(col_pos) - 1;
    end else begin
      crow = int'(row_pos) - 2;
      ccol = w - 1;
    end
    if (crow >= 0 && crow < h && ccol < w) begin
      lowest = PIX_MAX;
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          nr = crow + r - 1;
          nc = ccol + c - 1;
          if (mask_r[r * TAPS + c] && nr >= 0 && nr < h && nc >= 0 && nc < w &&
              win[r][c] < lowest) begin
            lowest = win[r][c];
          end
        end
      end
      res.value = lowest;
      res.last  = (crow == h - 1) && (ccol == w - 1);
      eroded_q.push_back(res);
    end
    col_pos++;
    if (int'(col_pos) >= w) begin
      col_pos = '0;
      row_pos++;
    end
  endfunction

  function automatic void check_beat();
    eroded_px_t want;
    if (eroded_q.size() == 0) begin
      $display("%0t: output beat with nothing expected, actual value %0d last %0b",
               $time, out_eroded_value, out_frame_last);
      fail_count++;
      return;
    end
    want = eroded_q.pop_front();
    if (out_eroded_value !== want.value) begin
      $display("%0t: eroded_value mismatch, expected %0d, actual %0d",
               $time, want.value, out_eroded_value);
      fail_count++;
    end
    if (out_frame_last !== want.last) begin
      $display("%0t: frame_last mismatch, expected %0b, actual %0b",
               $time, want.last, out_frame_last);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_r  = WIDTH_RST;
      height_r = HEIGHT_RST;
      mask_r   = MASK_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      fill_window();
      row_pos = '0;
      col_pos = '0;
      eroded_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  width_r  = cfg_data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_r = cfg_data[HEIGHT_REG_W-1:0];
          REG_KERNEL_MASK:  mask_r   = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_beat(in_pixel_value, in_frame_start, in_flush);
      if (out_valid && !out_stall) check_beat();
    end
    expect_depth = eroded_q.size();
  end

endmodule

>>> test/grayscale_erosion_3x3_test.sv
// ----------------------------------------------------------------------------
// grayscale_erosion_3x3_test - top-level testbench for the erosion block
// Streams short directed frames, then random frames: clean frames with a
// drain, frames cut short by a new frame start, frames whose width and
// mask change part way through, and beats sent after the drain. Image
// sizes stay small apart from a few frames at the size limits, the
// largest of which are only started. Sender gaps and receiver stalls
// rotate through four patterns frame by frame.
// ----------------------------------------------------------------------------
module grayscale_erosion_3x3_test;
  import ge3_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BEATS  = 560;
  localparam int SETTLE_CYCLES = 16;
  localparam int EXTREME_CASES = 5;
  localparam int EXTREME_BEATS = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_value = '0;
  logic                  in_frame_start = 1'b0;
  logic                  in_flush = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_eroded_value;
  logic                  out_frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int expect_depth;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beat_total = 0;
  int cur_w;
  int cur_h;
  int pix_lo = 0;
  int pix_hi = 255;

  grayscale_erosion_3x3 u_dut (.*);

  ge3_erosion_checker u_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall   <= ($urandom_range(99) < recv_stall_pct);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(input logic [PIX_W-1:0] pv, input logic fs, input logic fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pv;
    in_frame_start <= fs;
    in_flush       <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beat_total++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(9) == 0) return PIX_W'($urandom_range(255));
    return PIX_W'($urandom_range(pix_hi, pix_lo));
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // flush beats inside the image stand in for white pixels
  task automatic send_pixels(input int count, input bit start);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(24) == 0) send_beat(PIX_W'($urandom), start && i == 0, 1'b1);
      else send_beat(pick_pixel(), start && i == 0, 1'b0);
    end
  endtask

  task automatic drain(input int w);
    for (int i = 0; i <= w; i++) send_beat(PIX_W'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_frame(input int w, input int h);
    send_pixels(w * h, 1'b1);
    drain(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expect_depth != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int w_data,
                           input int h_data,
                           input logic [MASK_W-1:0] mask);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_data));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_data));
    write_reg(REG_KERNEL_MASK, CFG_DATA_W'(mask));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_phase(input int frame_idx);
    case (frame_idx % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  task automatic run_extreme(input int idx);
    case (idx)
      0: begin configure(1024, 1, pick_mask()); cur_w = 1024; cur_h = 1; end
      // bits above the width field are dropped
      1: begin configure('h1805, 3, pick_mask()); cur_w = 5; cur_h = 3; end
      2: begin configure(1, 4096, pick_mask()); cur_w = 1; cur_h = 4096; end
      // oversize width clamps to the line store length
      3: begin configure(2047, 2, pick_mask()); cur_w = 1024; cur_h = 2; end
      default: begin configure(1, 1, '1); cur_w = 1; cur_h = 1; end
    endcase
    // large frames are only started; the next frame start abandons them
    if (cur_w * cur_h + cur_w + 1 > EXTREME_BEATS) send_pixels(EXTREME_BEATS, 1'b1);
    else send_frame(cur_w, cur_h);
  endtask

  // width shrinks and mask changes part way into a frame, at least one row in
  task automatic send_split_frame();
    int split;
    int w2;
    int j;
    int k;
    int rest;
    split = $urandom_range(cur_w * cur_h - 1, cur_w);
    send_pixels(split, 1'b1);
    w2 = $urandom_range(cur_w, 1);
    configure(w2, cur_h, pick_mask());
    j = split % cur_w;
    k = split / cur_w;
    // a column already past the new width wraps after one beat
    rest = ((j >= w2) ? 1 : w2 - j) + (cur_h - 1 - k) * w2;
    send_pixels(rest, 1'b0);
    drain(w2);
    cur_w = w2;
  endtask

  initial begin
    int frame_idx;
    int kind;
    int ext_done;
    int small_beats;
    int mark;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x2 frame with pixel extremes, then beats past the drain
    configure(3, 2, '1);
    send_beat(8'd0, 1'b1, 1'b0);
    send_beat(8'd255, 1'b0, 1'b0);
    send_beat(8'd128, 1'b0, 1'b0);
    send_beat(8'd255, 1'b0, 1'b0);
    send_beat(8'd1, 1'b0, 1'b0);
    send_beat(8'd254, 1'b0, 1'b0);
    drain(3);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);

    // zero sizes act as 1x1, empty mask gives white
    configure(0, 0, '0);
    send_beat(8'd0, 1'b1, 1'b0);
    drain(1);

    // center tap only; frame opens on a flush beat
    configure(2, 3, 9'h010);
    send_beat(8'd7, 1'b1, 1'b1);
    send_beat(8'd3, 1'b0, 1'b0);
    send_beat(8'd200, 1'b0, 1'b0);
    send_beat(8'd9, 1'b0, 1'b1);
    send_beat(8'd0, 1'b0, 1'b0);
    send_beat(8'd255, 1'b0, 1'b0);
    drain(2);
    cur_w = 2;
    cur_h = 3;

    frame_idx   = 0;
    ext_done    = 0;
    small_beats = 0;
    while (small_beats < RANDOM_BEATS || ext_done < EXTREME_CASES) begin
      set_phase(frame_idx);
      pix_lo = $urandom_range(255);
      pix_hi = $urandom_range(255, pix_lo);
      if (frame_idx % 3 == 2 && ext_done < EXTREME_CASES) begin
        run_extreme(ext_done);
        ext_done++;
      end else begin
        // back to small sizes after a frame at the limits
        if ($urandom_range(2) == 0 || cur_w > 16 || cur_h > 10) begin
          cur_w = $urandom_range(16, 1);
          cur_h = $urandom_range(10, 1);
          configure(cur_w, cur_h, pick_mask());
        end
        mark = beat_total;
        kind = $urandom_range(99);
        if (kind < 65) begin
          send_frame(cur_w, cur_h);
        end else if (kind < 80) begin
          // cut short; the next frame start abandons it
          if (cur_w * cur_h > 1) send_pixels($urandom_range(cur_w * cur_h - 1, 1), 1'b1);
          else send_frame(cur_w, cur_h);
        end else if (kind < 90) begin
          if (cur_h >= 2) send_split_frame();
          else send_frame(cur_w, cur_h);
        end else begin
          send_frame(cur_w, cur_h);
        end
        small_beats += beat_total - mark;
        if (kind >= 90) begin
          // trailing junk after the drain: no results, then dropped
          for (int i = $urandom_range(cur_w + 3, 1); i > 0; i--) begin
            send_beat(PIX_W'($urandom), 1'b0, 1'($urandom_range(1)));
          end
        end
      end
      frame_idx++;
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
